[rtl/lru_block_buffer_cache_assert.svh]
// assertion macros shared by the buffer cache checker
// no dependencies
`ifndef LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
// property that must hold on every clock edge outside reset
`define LBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked from reset onward too
`define LBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/lbc_pkg.sv]
// shared types, codes and constants of the lru buffer cache
// no dependencies
package lbc_pkg;
  localparam int NumSlotsDef = 32;
  localparam int RefMax      = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_GET  = 2'd0,
    FUNC_PUT  = 2'd1,
    FUNC_FREE = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOSLOT = 2'd1,
    ST_BADPUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LC_ACT_HIT = 2'd0,
    LC_INA_HIT = 2'd1,
    LC_MISS    = 2'd2
  } lcase_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_UNLINK, S_INSERT, S_FREE, S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request
    logic look;    // run the tag compare
    logic decide;  // apply counter/tag updates and pick relink
    logic unlink;  // unlink the selected node
    logic insert;  // insert it into the target list
    logic free_step; // one step of the freemem walk
  } lbc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic do_relink;  // decide found a relink to perform
    logic free_done;  // walk finished
  } lbc_sts_t;
endpackage

[rtl/lru_block_buffer_cache.sv]
// lru buffer cache of NUM_SLOTS slots with active and inactive recency lists.
// A get or put that relinks its slot runs the steps capture, tag compare,
// decide, unlink and insert before its result is pushed (insert reads links
// that unlink writes, so the two are separate steps); a get or put that leaves
// the lists alone (a put that keeps a nonzero count, a bad put, a miss with no
// inactive slot, an unused code) stops after decide. A freemem walks the
// inactive slots from the tail, at most NUM_SLOTS of them. One item is in
// work at a time; the result sits in an output register, a waiting result holds
// off the next one, and the next transaction can be accepted in the cycle after
// the result register loads. depends on lbc_pkg, lbc_ctrl, lbc_dp
module lru_block_buffer_cache #(
  parameter int NUM_SLOTS = lbc_pkg::NumSlotsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // func[1:0], block_number[33:2],
                                   // slot_index[39:34], free_count[46:40]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata   // slot[5:0], status[7:6], lookup_case[9:8],
                                   // need_alloc[10], need_read[11],
                                   // freed_count[18:12], freed_mask[82:19]
);
  import lbc_pkg::*;

  lbc_cmd_t cmd;
  lbc_sts_t sts;
  logic idle, res_push, in_fire;
  logic [5:0] slot;
  logic [1:0] status, lookup_case;
  logic need_alloc, need_read;
  logic [6:0] freed_count;
  logic [63:0] freed_mask;
  logic out_valid_r;
  logic [87:0] out_data_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;

  lbc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .func(in_tdata[1:0]), .sts,
    .out_busy(out_valid_r && !out_tready), .cmd, .idle, .res_push
  );

  lbc_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .func(in_tdata[1:0]), .block_number(in_tdata[33:2]),
    .slot_index(in_tdata[39:34]), .free_count(in_tdata[46:40]), .sts,
    .slot, .status, .lookup_case, .need_alloc, .need_read, .freed_count,
    .freed_mask
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_push) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_push)
      out_data_r <= {5'd0, freed_mask, freed_count, need_read, need_alloc,
                     lookup_case, status, slot};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

[rtl/lbc_ctrl.sv]
// controller state machine of the lru buffer cache
// depends on lbc_pkg
module lbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        func,
  input  lbc_pkg::lbc_sts_t sts,
  input  logic              out_busy,
  output lbc_pkg::lbc_cmd_t cmd,
  output logic              idle,
  output logic              res_push
);
  import lbc_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    idle      = 1'b0;
    res_push  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = (func == FUNC_FREE) ? S_FREE : S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = sts.do_relink ? S_UNLINK : S_DONE;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt = S_DONE;
      end
      S_FREE: begin
        if (sts.free_done) state_nxt = S_DONE;
        else cmd.free_step = 1'b1;
      end
      S_DONE: begin
        if (!out_busy) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[rtl/lbc_dp.sv]
// datapath of the lru buffer cache: slot state, links and result fields
// depends on lbc_pkg
module lbc_dp #(
  parameter int NUM_SLOTS = lbc_pkg::NumSlotsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lbc_pkg::lbc_cmd_t cmd,
  input  logic [1:0]        func,
  input  logic [31:0]       block_number,
  input  logic [5:0]        slot_index,
  input  logic [6:0]        free_count,
  output lbc_pkg::lbc_sts_t sts,
  output logic [5:0]        slot,
  output logic [1:0]        status,
  output logic [1:0]        lookup_case,
  output logic              need_alloc,
  output logic              need_read,
  output logic [6:0]        freed_count,
  output logic [63:0]       freed_mask
);
  import lbc_pkg::*;

  localparam int NW = $clog2(NUM_SLOTS + 2);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [NW-1:0] ACT = NW'(NUM_SLOTS);
  localparam logic [NW-1:0] INA = NW'(NUM_SLOTS + 1);

  // slot state
  logic [31:0]          tag_r  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tv_r;
  logic [NUM_SLOTS-1:0] act_r;   // slot sits on the active list
  logic [NUM_SLOTS-1:0] dp_r;
  logic [15:0]          rc_r   [NUM_SLOTS];
  logic [NW-1:0]        nx_r   [NUM_SLOTS];
  logic [NW-1:0]        pv_r   [NUM_SLOTS];
  // list head links: active and inactive
  logic [NW-1:0]        anx_r, apv_r, inx_r, ipv_r;

  // request and working registers
  logic [1:0]    func_r;
  logic [31:0]   bn_r;
  logic [5:0]    si_r;
  logic [6:0]    lim_r;
  logic [NUM_SLOTS-1:0] hit_act_r, hit_ina_r;
  logic [NW-1:0] node_r, head_r, walk_r;
  logic          front_r;
  logic [5:0]    slot_r;
  logic [1:0]    status_r, lcase_r;
  logic          alloc_r, rd_r;
  logic [6:0]    freed_r;
  logic [63:0]   mask_r;

  // one-hot hit lookup; tags are unique among valid slots of one list
  logic [SW-1:0] ha_idx, hi_idx;
  logic          ha_any, hi_any;
  always_comb begin
    ha_idx = '0;
    hi_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit_act_r[i]) ha_idx = SW'(i);
      if (hit_ina_r[i]) hi_idx = SW'(i);
    end
    ha_any = |hit_act_r;
    hi_any = |hit_ina_r;
  end

  logic [NW-1:0] tail_ina;
  logic [SW-1:0] si_s, wk_s, tl_s, nd_s;
  logic          si_ok;
  assign tail_ina = ipv_r;
  assign si_s     = si_r[SW-1:0];
  assign wk_s     = walk_r[SW-1:0];
  assign tl_s     = tail_ina[SW-1:0];
  assign nd_s     = node_r[SW-1:0];
  assign si_ok    = ({1'b0, si_r} < 7'(NUM_SLOTS));

  // neighbors of the selected node and of the target head
  logic [NW-1:0] n_nx, n_pv, h_nx, h_pv;
  always_comb begin
    n_nx = nx_r[nd_s];
    n_pv = pv_r[nd_s];
    h_nx = (head_r == ACT) ? anx_r : inx_r;
    h_pv = (head_r == ACT) ? apv_r : ipv_r;
  end

  logic walk_ok;
  assign walk_ok = (walk_r < ACT) && ({1'b0, freed_r} < {1'b0, lim_r});
  assign sts.free_done = !walk_ok;
  assign sts.do_relink = (func_r == FUNC_GET)
                         ? (ha_any || hi_any || (tail_ina < ACT))
                         : ((func_r == FUNC_PUT) && si_ok
                            && (rc_r[si_s] == 16'd1));

  // control registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r  <= '0;
      dp_r  <= '0;
      act_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) rc_r[i] <= '0;
      anx_r <= ACT;
      apv_r <= ACT;
      inx_r <= '0;
      ipv_r <= NW'(NUM_SLOTS - 1);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        nx_r[i] <= (i + 1 < NUM_SLOTS) ? NW'(i + 1) : INA;
        pv_r[i] <= (i == 0) ? INA : NW'(i - 1);
      end
    end else begin
      // decide: counters, tags, data bits
      if (cmd.decide) begin
        if (func_r == FUNC_GET) begin
          if (ha_any) begin
            if (rc_r[ha_idx] != 16'(RefMax)) rc_r[ha_idx] <= rc_r[ha_idx] + 16'd1;
          end else if (hi_any) begin
            if (rc_r[hi_idx] != 16'(RefMax)) rc_r[hi_idx] <= rc_r[hi_idx] + 16'd1;
            dp_r[hi_idx] <= 1'b1;
          end else if (tail_ina < ACT) begin
            tv_r[tl_s] <= 1'b1;
            rc_r[tl_s] <= 16'd1;
            dp_r[tl_s] <= 1'b1;
          end
        end else if (func_r == FUNC_PUT && si_ok && rc_r[si_s] != 16'd0) begin
          rc_r[si_s] <= rc_r[si_s] - 16'd1;
        end
      end
      // unlink node from its list
      if (cmd.unlink) begin
        if (n_pv == ACT) anx_r <= n_nx;
        else if (n_pv == INA) inx_r <= n_nx;
        else nx_r[n_pv[SW-1:0]] <= n_nx;
        if (n_nx == ACT) apv_r <= n_pv;
        else if (n_nx == INA) ipv_r <= n_pv;
        else pv_r[n_nx[SW-1:0]] <= n_pv;
      end
      // insert at head front or tail
      if (cmd.insert) begin
        act_r[nd_s] <= (head_r == ACT);
        if (front_r) begin
          nx_r[nd_s] <= h_nx;
          pv_r[nd_s] <= head_r;
          if (h_nx == ACT) apv_r <= node_r;
          else if (h_nx == INA) ipv_r <= node_r;
          else pv_r[h_nx[SW-1:0]] <= node_r;
          if (head_r == ACT) anx_r <= node_r;
          else inx_r <= node_r;
        end else begin
          pv_r[nd_s] <= h_pv;
          nx_r[nd_s] <= head_r;
          if (h_pv == ACT) anx_r <= node_r;
          else if (h_pv == INA) inx_r <= node_r;
          else nx_r[h_pv[SW-1:0]] <= node_r;
          if (head_r == ACT) apv_r <= node_r;
          else ipv_r <= node_r;
        end
      end
      // freemem walk drops data bits
      if (cmd.free_step && dp_r[wk_s]) dp_r[wk_s] <= 1'b0;
    end
  end

  // tag store, written on a miss that takes an inactive slot
  always_ff @(posedge clk) begin
    if (cmd.decide && func_r == FUNC_GET && !ha_any && !hi_any && tail_ina < ACT)
      tag_r[tl_s] <= bn_r;
  end

  // request capture, compare and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= func;
      bn_r     <= block_number;
      si_r     <= slot_index;
      lim_r    <= (free_count > 7'(NUM_SLOTS)) ? 7'(NUM_SLOTS) : free_count;
      slot_r   <= '0;
      status_r <= ST_OK;
      lcase_r  <= LC_ACT_HIT;
      alloc_r  <= 1'b0;
      rd_r     <= 1'b0;
      freed_r  <= '0;
      mask_r   <= '0;
      walk_r   <= ipv_r;
    end
    if (cmd.look) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        hit_act_r[i] <= tv_r[i] && act_r[i] && (tag_r[i] == bn_r);
        hit_ina_r[i] <= tv_r[i] && !act_r[i] && (tag_r[i] == bn_r);
      end
    end
    if (cmd.decide) begin
      head_r  <= ACT;
      front_r <= 1'b1;
      if (func_r == FUNC_GET) begin
        if (ha_any) begin
          node_r <= NW'(ha_idx);
          slot_r <= 6'(ha_idx);
        end else if (hi_any) begin
          node_r  <= NW'(hi_idx);
          slot_r  <= 6'(hi_idx);
          lcase_r <= LC_INA_HIT;
          alloc_r <= !dp_r[hi_idx];
          rd_r    <= !dp_r[hi_idx];
        end else begin
          lcase_r <= LC_MISS;
          if (tail_ina < ACT) begin
            node_r  <= tail_ina;
            front_r <= 1'b0;
            slot_r  <= 6'(tl_s);
            alloc_r <= !dp_r[tl_s];
            rd_r    <= 1'b1;
          end else begin
            status_r <= ST_NOSLOT;
          end
        end
      end else if (func_r == FUNC_PUT) begin
        node_r <= NW'(si_s);
        head_r <= INA;
        if (!si_ok || rc_r[si_s] == 16'd0) status_r <= ST_BADPUT;
      end
    end
    if (cmd.free_step) begin
      if (dp_r[wk_s]) begin
        freed_r <= freed_r + 7'd1;
        mask_r[wk_s] <= 1'b1;
      end
      walk_r <= pv_r[wk_s];
    end
  end

  assign slot        = slot_r;
  assign status      = status_r;
  assign lookup_case = lcase_r;
  assign need_alloc  = alloc_r;
  assign need_read   = rd_r;
  assign freed_count = freed_r;
  assign freed_mask  = mask_r;
endmodule

[rtl/lbc_checker.sv]
// port-level checker of the lru buffer cache, bound to the top level
// depends on lru_block_buffer_cache_assert.svh
`include "lru_block_buffer_cache_assert.svh"
module lbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  `LBC_ASSERT(a_no_accept_next, (in_tvalid && in_tready) |=> !in_tready, "accept twice")
  `LBC_ASSERT(a_hold, (out_tvalid && !out_tready) |=> $stable(out_tdata), "result changed")
  `LBC_ASSERT(a_status, !out_tvalid || out_tdata[7:6] != 2'd3, "bad status")
  `LBC_ASSERT(a_cnt, !out_tvalid || out_tdata[18:12] <= 7'd64, "freed count too big")
  `LBC_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_tvalid, "valid after reset")
endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

[tb/testbench.sv]
// testbench for lru_block_buffer_cache: drives get/put/freemem transactions,
// predicts each result with a local model of the recency lists and compares.
// depends on lbc_pkg and lru_block_buffer_cache
`timescale 1ns / 100ps

module testbench;
  import lbc_pkg::*;

  localparam int NS = NumSlotsDef;
  localparam int AHEAD = NS;
  localparam int IHEAD = NS + 1;

  typedef struct packed {
    logic [63:0] freed_mask;
    logic [6:0]  freed_count;
    logic        need_read;
    logic        need_alloc;
    logic [1:0]  lookup_case;
    logic [1:0]  status;
    logic [5:0]  slot;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [87:0] out_tdata;

  lru_block_buffer_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the cache
  logic [31:0] tag_m [NS];
  logic        tvalid_m [NS];
  logic [15:0] refs_m [NS];
  logic        present_m [NS];
  int          nxt [NS+2];
  int          prv [NS+2];
  logic [31:0] used_blocks [$];

  cache_result_t pending_results [$];
  int errors = 0;
  int hold_off = 0;
  bit quiet_rx = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void model_reset();
    for (int i = 0; i < NS; i++) begin
      tag_m[i] = '0; tvalid_m[i] = 0; refs_m[i] = 0; present_m[i] = 0;
      nxt[i] = (i + 1 < NS) ? i + 1 : IHEAD;
      prv[i] = (i == 0) ? IHEAD : i - 1;
    end
    nxt[AHEAD] = AHEAD; prv[AHEAD] = AHEAD;
    nxt[IHEAD] = 0; prv[IHEAD] = NS - 1;
  endfunction

  function automatic void move_node(input int n, input int h, input bit front);
    int p, q, f, b;
    p = prv[n]; q = nxt[n];
    nxt[p] = q; prv[q] = p;
    if (front) begin
      f = nxt[h];
      nxt[n] = f; prv[f] = n; prv[n] = h; nxt[h] = n;
    end else begin
      b = prv[h];
      prv[n] = b; nxt[b] = n; nxt[n] = h; prv[h] = n;
    end
  endfunction

  function automatic int lookup_list(input int h, input logic [31:0] bn);
    int n;
    n = nxt[h];
    for (int i = 0; i < NS && n < NS; i++) begin
      if (tvalid_m[n] && tag_m[n] == bn) return n;
      n = nxt[n];
    end
    return NS + 2;
  endfunction

  // predicts one result and updates the model state
  function automatic cache_result_t cache_predict(input func_t fn, input logic [31:0] bn,
                                                  input logic [5:0] si, input logic [6:0] fc);
    cache_result_t r;
    int n, lim;
    r = '0;
    case (fn)
      FUNC_GET: begin
        n = lookup_list(AHEAD, bn);
        if (n < NS) begin
          if (refs_m[n] != 16'hFFFF) refs_m[n]++;
          move_node(n, AHEAD, 1);
          r.slot = 6'(n); r.lookup_case = LC_ACT_HIT;
        end else begin
          n = lookup_list(IHEAD, bn);
          if (n < NS) begin
            if (refs_m[n] != 16'hFFFF) refs_m[n]++;
            move_node(n, AHEAD, 1);
            if (!present_m[n]) begin
              present_m[n] = 1; r.need_alloc = 1; r.need_read = 1;
            end
            r.slot = 6'(n); r.lookup_case = LC_INA_HIT;
          end else begin
            r.lookup_case = LC_MISS;
            n = prv[IHEAD];
            if (n >= NS) r.status = ST_NOSLOT;
            else begin
              tag_m[n] = bn; tvalid_m[n] = 1; refs_m[n] = 1;
              move_node(n, AHEAD, 0);
              r.need_alloc = !present_m[n];
              present_m[n] = 1; r.need_read = 1; r.slot = 6'(n);
            end
          end
        end
      end
      FUNC_PUT: begin
        if (si >= NS || refs_m[si] == 0) r.status = ST_BADPUT;
        else begin
          refs_m[si]--;
          if (refs_m[si] == 0) move_node(int'(si), IHEAD, 1);
        end
      end
      FUNC_FREE: begin
        lim = (fc > NS) ? NS : int'(fc);
        n = prv[IHEAD];
        for (int i = 0; i < NS && n < NS && r.freed_count < lim; i++) begin
          if (present_m[n]) begin
            present_m[n] = 0; r.freed_mask[n] = 1; r.freed_count++;
          end
          n = prv[n];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one transaction, sometimes followed by a random gap
  task automatic send_item(input func_t fn, input logic [31:0] bn,
                           input logic [5:0] si, input logic [6:0] fc);
    in_tdata <= {1'b0, fc, si, bn, fn};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(cache_predict(fn, bn, si, fc));
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (quiet_rx) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 9) < 7);
  end

  // result checker
  always @(posedge clk) begin
    cache_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[82:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got.slot, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.lookup_case != want.lookup_case)
          report_mismatch("lookup_case", got.lookup_case, want.lookup_case);
        if (got.need_alloc != want.need_alloc)
          report_mismatch("need_alloc", got.need_alloc, want.need_alloc);
        if (got.need_read != want.need_read)
          report_mismatch("need_read", got.need_read, want.need_read);
        if (got.freed_count != want.freed_count)
          report_mismatch("freed_count", got.freed_count, want.freed_count);
        if (got.freed_mask != want.freed_mask)
          report_mismatch("freed_mask", got.freed_mask, want.freed_mask);
      end
    end
  end

  function automatic logic [31:0] pick_block();
    if (used_blocks.size() > 0 && $urandom_range(0, 3) != 0)
      return used_blocks[$urandom_range(0, used_blocks.size() - 1)];
    pick_block = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 60);
    used_blocks.push_back(pick_block);
    if (used_blocks.size() > 48) void'(used_blocks.pop_front());
  endfunction

  // pick a slot likely to hold a reference
  function automatic logic [5:0] held_slot();
    for (int k = 0; k < 8; k++) begin
      int s;
      s = $urandom_range(0, NS - 1);
      if (refs_m[s] != 0) return 6'(s);
    end
    return 6'($urandom_range(0, 63));
  endfunction

  // extremes, every operation and the special cases
  task automatic test_directed();
    send_item(FUNC_FREE, 0, 0, 7'd64);
    send_item(FUNC_PUT, 0, 6'd0, 0);
    send_item(FUNC_PUT, 0, 6'd63, 7'd127);
    send_item(FUNC_GET, 32'hFFFF_FFFF, 0, 0);
    send_item(FUNC_GET, 32'hFFFF_FFFF, 0, 0);
    send_item(FUNC_GET, 32'h0, 6'd63, 7'd127);
    send_item(FUNC_PUT, 0, 6'd1, 0);
    send_item(FUNC_PUT, 0, 6'd1, 0);
    send_item(FUNC_PUT, 0, 6'd0, 0);
    send_item(FUNC_PUT, 0, 6'd0, 0);
    send_item(FUNC_GET, 32'h0, 0, 0);
    send_item(FUNC_NOP, 32'hFFFF_FFFF, 6'd63, 7'd127);
    send_item(FUNC_FREE, 0, 0, 7'd1);
    send_item(FUNC_FREE, 0, 0, 7'd127);
    send_item(FUNC_PUT, 0, 6'd1, 0);
    // block 0 again: an active hit, its slot still holds references
    send_item(FUNC_GET, 32'h0, 0, 0);
  endtask

  // fill every slot so a miss finds no inactive slot, then put each slot, twice where it still holds a reference
  task automatic test_no_slot();
    for (int i = 0; i < NS + 2; i++) send_item(FUNC_GET, 32'h1000 + i, 0, 0);
    for (int i = 0; i < NS; i++) send_item(FUNC_PUT, 0, 6'(i), 0);
    for (int i = 0; i < NS; i++)
      if (refs_m[i] != 0) send_item(FUNC_PUT, 0, 6'(i), 0);
  endtask

  // long receiver stall while the sender keeps offering
  task automatic test_backpressure();
    hold_off <= 60;
    for (int i = 0; i < 12; i++) send_item(FUNC_GET, pick_block(), 0, 0);
  endtask

  // random mix of well formed get/put pairs plus noise
  task automatic test_random(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      quiet_rx <= (i / 150) % 3 == 1;
      sel = $urandom_range(0, 99);
      if (sel < 50)
        send_item(FUNC_GET, pick_block(), 6'($urandom()), 7'($urandom()));
      else if (sel < 85)
        send_item(FUNC_PUT, $urandom(), held_slot(), 7'($urandom()));
      else if (sel < 95)
        send_item(FUNC_FREE, $urandom(), 6'($urandom()), 7'($urandom_range(0, 127)));
      else if (sel < 98)
        send_item(FUNC_PUT, $urandom(), 6'($urandom()), 7'($urandom()));
      else
        send_item(FUNC_NOP, $urandom(), 6'($urandom()), 7'($urandom()));
    end
    quiet_rx <= 0;
  endtask

  initial begin
    int waited;
    model_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_slot();
    test_backpressure();
    test_random(1050);
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (NS + 10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("lru_block_buffer_cache: match");
    else $display("lru_block_buffer_cache: mismatch");
    $finish;
  end

  // timeout
  initial begin
    #3_000_000;
    $display("lru_block_buffer_cache: mismatch");
    $finish;
  end
endmodule
